[design/rhce_pkg.sv]
// Shared types, constants and helper functions for the ROM header checksum engine.
package rhce_pkg;

  localparam int WORD_W      = 32;
  localparam int TAP_WORDS   = 64;
  localparam int IDX_W       = $clog2(TAP_WORDS);
  localparam int VAR_W       = 3;
  localparam int IN_TDATA_W  = ((WORD_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 2 * WORD_W;

  // Item kinds carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Variant codes
  localparam logic [VAR_W-1:0] VAR_6102 = 3'd0;
  localparam logic [VAR_W-1:0] VAR_6103 = 3'd1;
  localparam logic [VAR_W-1:0] VAR_6105 = 3'd2;
  localparam logic [VAR_W-1:0] VAR_6106 = 3'd3;
  localparam logic [VAR_W-1:0] VAR_DISK = 3'd4;
  localparam logic [VAR_W-1:0] VAR_8303 = 3'd5;
  localparam logic [VAR_W-1:0] VAR_8401 = 3'd6;
  localparam logic [VAR_W-1:0] VAR_5101 = 3'd7;

  // Data word held in the input register
  typedef struct packed {
    logic              first;
    logic              last;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] rotated;
  } item_t;

  // Accumulator set; the tap sum is kept as tap + pend to split the add chain
  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] carry;
    logic [WORD_W-1:0] xsum;
    logic [WORD_W-1:0] rot;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] tap;
    logic [WORD_W-1:0] pend;
  } acc_t;

  // Seed per variant
  function automatic logic [WORD_W-1:0] seed_of(input logic [VAR_W-1:0] v);
    logic [WORD_W-1:0] s;
    case (v)
      VAR_6102: s = 32'hF8CA4DDC;
      VAR_6103: s = 32'hA3886759;
      VAR_6105: s = 32'hDF26F436;
      VAR_6106: s = 32'h1FEA617A;
      VAR_DISK: s = 32'h861AE3A7;
      VAR_8303: s = 32'h8331D4CA;
      VAR_8401: s = 32'h0D8303E2;
      default:  s = 32'h95104FDD;
    endcase
    return s;
  endfunction

  // Rotate left by the low five bits of the word itself; zero leaves it unchanged
  function automatic logic [WORD_W-1:0] rot_self(input logic [WORD_W-1:0] w);
    logic [2*WORD_W-1:0] dbl;
    dbl = {w, w} << w[4:0];
    return dbl[2*WORD_W-1:WORD_W];
  endfunction

endpackage

[design/rhce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rhce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/rhce_accum.sv]
// Running accumulators: one data word updates all six sums per cycle while en_i is high.
module rhce_accum (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  rhce_pkg::item_t                item_i,
  input  logic [rhce_pkg::VAR_W-1:0]     variant_i,
  input  logic [rhce_pkg::WORD_W-1:0]    tap_rd_i,
  output rhce_pkg::acc_t                 acc_d_o
);
  import rhce_pkg::*;

  acc_t              acc_q;
  acc_t              acc_d;
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] sum_b, carry_b, xsum_b, rot_b, mix_b, tap_b;
  logic [WORD_W:0]   sum_wide;
  logic [WORD_W-1:0] w;

  assign w    = item_i.word;
  assign seed = seed_of(variant_i);

  // pick the seed on the first word of a run, else the running values
  always_comb begin
    if (item_i.first) begin
      sum_b   = seed;
      carry_b = seed;
      xsum_b  = seed;
      rot_b   = seed;
      mix_b   = seed;
      tap_b   = seed;
    end else begin
      sum_b   = acc_q.sum;
      carry_b = acc_q.carry;
      xsum_b  = acc_q.xsum;
      rot_b   = acc_q.rot;
      mix_b   = acc_q.mix;
      tap_b   = acc_q.tap + acc_q.pend;
    end
  end

  // per-word update
  always_comb begin
    sum_wide   = {1'b0, sum_b} + {1'b0, w};
    acc_d.sum  = sum_wide[WORD_W-1:0];
    acc_d.xsum = xsum_b ^ w;
    acc_d.rot  = rot_b + item_i.rotated;
    acc_d.tap  = tap_b;

    // carry rule on overflow of the plain sum
    if (!sum_wide[WORD_W]) begin
      acc_d.carry = carry_b;
    end else if (variant_i == VAR_DISK || variant_i == VAR_8303) begin
      acc_d.carry = carry_b ^ xsum_b;
    end else begin
      acc_d.carry = carry_b + 32'd1;
    end

    // mix rule
    if (mix_b < w) begin
      acc_d.mix = acc_d.sum ^ w ^ mix_b;
    end else if (variant_i == VAR_8303) begin
      acc_d.mix = mix_b + item_i.rotated;
    end else begin
      acc_d.mix = mix_b ^ item_i.rotated;
    end

    // tap term, folded into the tap sum on the next word or at the combine
    if (variant_i == VAR_6105) begin
      acc_d.pend = w ^ tap_rd_i;
    end else begin
      acc_d.pend = w ^ acc_d.rot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_d_o = acc_d;

endmodule

[design/rhce_combine.sv]
// Final combine pipeline: capture, multiply/fold, combine into the output register.
module rhce_combine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rhce_pkg::acc_t                    acc_i,
  input  logic [rhce_pkg::VAR_W-1:0]        variant_i,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rhce_pkg::OUT_TDATA_W-1:0]  m_axis_tdata  // checksum_one, checksum_two
);
  import rhce_pkg::*;

  logic              c1_valid_q, c2_valid_q, out_valid_q;
  acc_t              c1_acc_q;
  logic [VAR_W-1:0]  c1_var_q, c2_var_q;
  logic [WORD_W-1:0] prod1_q, prod2_q, tapf_q, x1_q, x2_q, xsum_q;
  logic [WORD_W-1:0] chk1_d, chk2_d, chk1_q, chk2_q;
  logic              out_free, c2_move, c2_free, c1_move, c1_free;

  // stage advance
  assign out_free   = !out_valid_q || m_axis_tready;
  assign c2_move    = c2_valid_q && out_free;
  assign c2_free    = !c2_valid_q || c2_move;
  assign c1_move    = c1_valid_q && c2_free;
  assign c1_free    = !c1_valid_q || c1_move;
  assign in_ready_o = c1_free;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q  <= 1'b0;
      c2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i) begin
        c1_valid_q <= 1'b1;
      end else if (c1_move) begin
        c1_valid_q <= 1'b0;
      end
      if (c1_move) begin
        c2_valid_q <= 1'b1;
      end else if (c2_move) begin
        c2_valid_q <= 1'b0;
      end
      if (c2_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // capture final accumulators
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      c1_acc_q <= acc_i;
      c1_var_q <= variant_i;
    end
  end

  // products, tap fold and xor terms
  always_ff @(posedge clk_i) begin
    if (c1_move) begin
      prod1_q  <= c1_acc_q.sum * c1_acc_q.carry;
      prod2_q  <= c1_acc_q.rot * c1_acc_q.mix;
      tapf_q   <= c1_acc_q.tap + c1_acc_q.pend;
      x1_q     <= c1_acc_q.sum ^ c1_acc_q.carry;
      x2_q     <= c1_acc_q.rot ^ c1_acc_q.mix;
      xsum_q   <= c1_acc_q.xsum;
      c2_var_q <= c1_var_q;
    end
  end

  // final combine per variant
  always_comb begin
    case (c2_var_q) inside
      VAR_6103, VAR_5101: begin
        chk1_d = x1_q + xsum_q;
        chk2_d = x2_q + tapf_q;
      end
      VAR_6106: begin
        chk1_d = prod1_q + xsum_q;
        chk2_d = prod2_q + tapf_q;
      end
      default: begin
        chk1_d = x1_q ^ xsum_q;
        chk2_d = x2_q ^ tapf_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (c2_move) begin
      chk1_q <= chk1_d;
      chk2_q <= chk2_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {chk2_q, chk1_q};

  // checks
  a_c1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |=> c1_valid_q)
    else $error("combine capture lost an item");
  a_c2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c2_valid_q && !out_free) |=> c2_valid_q)
    else $error("stalled combine stage dropped its item");

endmodule

[design/rom_header_checksum_engine.sv]
// Top level of the ROM header checksum engine.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata word,table_index; tlast; tuser op
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata checksum_one,checksum_two
//  cfg      | in        | cfg_valid_i/cfg_ready_o      | variant
//
// One item per cycle unless stalled; a last data word's result passes through the input register,
// the accumulator update into capture, the product/fold stage and the output register.
// Tap table reads use the memory's registered read port, issued as the word is accepted.
// Reset clears control state only; the tap table holds nothing until loaded.
// Output stalls fill the combine stages; input stalls only once a last word cannot advance.
module rom_header_checksum_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rhce_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // word, table_index, zero pad
  input  logic                             s_axis_tlast,
  input  logic                             s_axis_tuser,  // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rhce_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // checksum_one, checksum_two
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rhce_pkg::VAR_W-1:0]       cfg_data_i
);
  import rhce_pkg::*;

  logic              in_acc, data_acc, load_acc;
  logic [WORD_W-1:0] word_in;
  logic [IDX_W-1:0]  idx_in, item_pos, pos_q;
  logic              fresh_q;
  logic [VAR_W-1:0]  variant_q;
  logic              a_valid_q, a_move;
  item_t             a_item_q;
  logic [WORD_W-1:0] tap_rd;
  acc_t              acc_d;
  logic              comb_ready;

  assign word_in  = s_axis_tdata[WORD_W-1:0];
  assign idx_in   = s_axis_tdata[WORD_W +: IDX_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign data_acc = in_acc && (s_axis_tuser == OP_DATA);
  assign load_acc = in_acc && (s_axis_tuser == OP_LOAD);
  assign item_pos = fresh_q ? '0 : pos_q;

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_6102;
    end else if (cfg_valid_i && cfg_ready_o) begin
      variant_q <= cfg_data_i;
    end
  end

  // run tracking at the input side: tap position and first-word flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
      pos_q   <= '0;
    end else if (data_acc) begin
      fresh_q <= s_axis_tlast;
      pos_q   <= item_pos + IDX_W'(1);
    end
  end

  // input register
  assign a_move        = a_valid_q && (!a_item_q.last || comb_ready);
  assign s_axis_tready = !a_valid_q || a_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (data_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      a_item_q.first   <= fresh_q;
      a_item_q.last    <= s_axis_tlast;
      a_item_q.word    <= word_in;
      a_item_q.rotated <= rot_self(word_in);
    end
  end

  // tap table
  rhce_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TAP_WORDS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (idx_in),
    .wdata_i (word_in),
    .re_i    (data_acc),
    .raddr_i (item_pos),
    .rdata_o (tap_rd)
  );

  rhce_accum u_accum (
    .clk_i     (clk_i),
    .en_i      (a_move),
    .item_i    (a_item_q),
    .variant_i (variant_q),
    .tap_rd_i  (tap_rd),
    .acc_d_o   (acc_d)
  );

  rhce_combine u_combine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (a_move && a_item_q.last),
    .in_ready_o    (comb_ready),
    .acc_i         (acc_d),
    .variant_i     (variant_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // checks
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> s_axis_tready)
    else $error("input refused with an empty input register");
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_acc && s_axis_tlast) |=> (fresh_q && a_valid_q && a_item_q.last))
    else $error("last word did not close the run");
  a_load_noitem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_acc && !a_valid_q) |=> !a_valid_q)
    else $error("table load entered the data path");

endmodule
